// File: design/dqbfe_pkg.sv
package dqbfe_pkg;

    // Register map of the configuration port
    localparam int unsigned CFG_INDEX_W = 1;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_PRESS_MS = 1'b1;

    // Counter widths and reset values
    localparam int unsigned DEBOUNCE_W   = 8;
    localparam int unsigned HELD_W       = 16;
    localparam int unsigned NUM_BUTTONS  = 2;
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_MS_RST   = 8'd50;
    localparam logic [HELD_W-1:0]     LONG_PRESS_MS_RST = 16'd3000;
    localparam logic [DEBOUNCE_W-1:0] SINCE_MAX         = '1;
    localparam logic [HELD_W-1:0]     HELD_MAX          = '1;

    // Result of one encoder decode
    typedef struct packed {
        logic signed [1:0] step;
        logic signed [1:0] rem;
    } dec_t;

    // Quadrature transition table, state is {A, B}
    function automatic logic signed [1:0] quad_delta(input logic [1:0] prev,
                                                     input logic [1:0] now);
        logic signed [1:0] d;
        case ({prev, now})
            4'b0001: d = -2'sd1;
            4'b0010: d =  2'sd1;
            4'b0100: d =  2'sd1;
            4'b0111: d = -2'sd1;
            4'b1000: d = -2'sd1;
            4'b1011: d =  2'sd1;
            4'b1101: d =  2'sd1;
            4'b1110: d = -2'sd1;
            default: d =  2'sd0;
        endcase
        return d;
    endfunction

    // Add the transition to the kept remainder and take one detent per two counts
    function automatic dec_t quad_decode(input logic [1:0] prev,
                                         input logic [1:0] now,
                                         input logic signed [1:0] rem);
        logic signed [1:0] d;
        logic signed [2:0] sum;
        dec_t r;
        d   = quad_delta(prev, now);
        sum = {rem[1], rem} + {d[1], d};
        if (sum == -3'sd2)
        begin
            r.step = -2'sd1;
            r.rem  =  2'sd0;
        end
        else if (sum == 3'sd2)
        begin
            r.step = 2'sd1;
            r.rem  = 2'sd0;
        end
        else
        begin
            r.step = 2'sd0;
            r.rem  = sum[1:0];
        end
        return r;
    endfunction

endpackage

// File: design/dual_quadrature_and_button_front_end.sv
// Two quadrature encoders and two active-low push buttons, sampled once per transfer.
// Each input transfer yields exactly one result: a signed detent step per encoder
// (one detent every two valid transitions, invalid double jumps ignored), a click
// per button on a debounced release that did not follow a long press, and a
// long-press event on button two once per press. Debounce and long-press times
// count the ms_tick flags carried in the samples. The block takes one sample
// every cycle while in_ready is high; a sample goes through an input register
// and one pass of decode and debounce logic into the result register, which
// offers its result on out_valid. in_ready drops only while both registers
// hold an item and out_ready is low. Write the configuration registers only
// while idle.
module dual_quadrature_and_button_front_end
(
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 cfg_we,
    input  logic [dqbfe_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [dqbfe_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 enc1_a,
    input  logic                                 enc1_b,
    input  logic                                 enc2_a,
    input  logic                                 enc2_b,
    input  logic                                 button1_level,
    input  logic                                 button2_level,
    input  logic                                 ms_tick,

    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [1:0]                    step1,
    output logic signed [1:0]                    step2,
    output logic                                 click1,
    output logic                                 click2,
    output logic                                 long_press2
);

    localparam int unsigned NB  = dqbfe_pkg::NUM_BUTTONS;
    localparam int unsigned DBW = dqbfe_pkg::DEBOUNCE_W;
    localparam int unsigned HW  = dqbfe_pkg::HELD_W;

    // Configuration registers
    logic [DBW-1:0] debounce_ms_reg;
    logic [HW-1:0]  long_press_ms_reg;

    // Input register
    logic           in_valid_reg;
    logic [1:0]     enc1_in_reg;
    logic [1:0]     enc2_in_reg;
    logic [NB-1:0]  level_in_reg;
    logic           tick_in_reg;

    // Result register
    logic              out_valid_reg;
    logic signed [1:0] step1_reg;
    logic signed [1:0] step2_reg;
    logic [NB-1:0]     click_reg;
    logic              long_press2_reg;

    // Decoder and button state
    logic [1:0]        enc1_prev_reg, enc2_prev_reg;
    logic signed [1:0] enc1_rem_reg, enc2_rem_reg;
    logic [NB-1:0]     btn_raw_reg, btn_stable_reg, long_taken_reg;
    logic [DBW-1:0]    since_reg [NB];
    logic [HW-1:0]     held_reg  [NB];

    logic [NB-1:0]     btn_raw_next, btn_stable_next, long_taken_next;
    logic [DBW-1:0]    since_next [NB];
    logic [HW-1:0]     held_next  [NB];
    logic [NB-1:0]     click_next, long_next;

    dqbfe_pkg::dec_t   dec1, dec2;
    logic              advance;

    // Move an item to the result register when that register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg   <= dqbfe_pkg::DEBOUNCE_MS_RST;
            long_press_ms_reg <= dqbfe_pkg::LONG_PRESS_MS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dqbfe_pkg::REG_DEBOUNCE_MS:   debounce_ms_reg   <= cfg_data[DBW-1:0];
                dqbfe_pkg::REG_LONG_PRESS_MS: long_press_ms_reg <= cfg_data[HW-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the sample until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            enc1_in_reg  <= {enc1_a, enc1_b};
            enc2_in_reg  <= {enc2_a, enc2_b};
            level_in_reg <= {button2_level, button1_level};
            tick_in_reg  <= ms_tick;
        end
    end

    // Encoder decode
    assign dec1 = dqbfe_pkg::quad_decode(enc1_prev_reg, enc1_in_reg, enc1_rem_reg);
    assign dec2 = dqbfe_pkg::quad_decode(enc2_prev_reg, enc2_in_reg, enc2_rem_reg);

    // Button debounce, click and long-press logic, one copy per button
    always_comb
    begin
        for (int i = 0; i < NB; i++)
        begin
            held_next[i]       = held_reg[i];
            since_next[i]      = since_reg[i];
            btn_raw_next[i]    = btn_raw_reg[i];
            btn_stable_next[i] = btn_stable_reg[i];
            long_taken_next[i] = long_taken_reg[i];
            click_next[i]      = 1'b0;
            long_next[i]       = 1'b0;

            // count stable press time
            if (!btn_stable_reg[i] && tick_in_reg && held_reg[i] != dqbfe_pkg::HELD_MAX)
                held_next[i] = held_reg[i] + 1'b1;

            // restart the quiet time on any raw change
            if (level_in_reg[i] != btn_raw_reg[i])
            begin
                btn_raw_next[i] = level_in_reg[i];
                since_next[i]   = '0;
            end
            else if (tick_in_reg && since_reg[i] != dqbfe_pkg::SINCE_MAX)
            begin
                since_next[i] = since_reg[i] + 1'b1;
            end

            if (since_next[i] >= debounce_ms_reg)
            begin
                // take the new stable level
                if (btn_stable_reg[i] != btn_raw_next[i])
                begin
                    btn_stable_next[i] = btn_raw_next[i];
                    if (!btn_raw_next[i])
                    begin
                        held_next[i]       = '0;
                        long_taken_next[i] = 1'b0;
                    end
                    else if (!long_taken_reg[i])
                    begin
                        click_next[i] = 1'b1;
                    end
                end
                // flag a long press once per press
                if (!btn_stable_next[i] && !long_taken_next[i]
                    && held_next[i] >= long_press_ms_reg)
                begin
                    long_taken_next[i] = 1'b1;
                    long_next[i]       = 1'b1;
                end
            end
        end
    end

    // State update, one item per advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc1_prev_reg  <= '0;
            enc2_prev_reg  <= '0;
            enc1_rem_reg   <= '0;
            enc2_rem_reg   <= '0;
            btn_raw_reg    <= '1;
            btn_stable_reg <= '1;
            long_taken_reg <= '0;
            for (int i = 0; i < NB; i++)
            begin
                since_reg[i] <= dqbfe_pkg::SINCE_MAX;
                held_reg[i]  <= '0;
            end
        end
        else if (advance)
        begin
            enc1_prev_reg  <= enc1_in_reg;
            enc2_prev_reg  <= enc2_in_reg;
            enc1_rem_reg   <= dec1.rem;
            enc2_rem_reg   <= dec2.rem;
            btn_raw_reg    <= btn_raw_next;
            btn_stable_reg <= btn_stable_next;
            long_taken_reg <= long_taken_next;
            for (int i = 0; i < NB; i++)
            begin
                since_reg[i] <= since_next[i];
                held_reg[i]  <= held_next[i];
            end
        end
    end

    // Result register: load on advance, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            step1_reg       <= dec1.step;
            step2_reg       <= dec2.step;
            click_reg       <= click_next;
            long_press2_reg <= long_next[1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign step1       = step1_reg;
    assign step2       = step2_reg;
    assign click1      = click_reg[0];
    assign click2      = click_reg[1];
    assign long_press2 = long_press2_reg;

    // A release click and a long press can never come from the same sample
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(click_reg[1] && long_press2_reg))
        else $error("click2 and long_press2 in one result");

    // Steps and remainders stay within -1..+1
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (step1_reg != 2'b10 && step2_reg != 2'b10))
        else $error("detent step out of range");

    assert property (@(posedge clk) disable iff (!rst_n)
        enc1_rem_reg != 2'b10 && enc2_rem_reg != 2'b10)
        else $error("encoder remainder out of range");

    // A new result only comes from a held sample
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without a sample");

endmodule
